FILE: sv/rhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL classifier package
// Request and response types, pipeline stage types and code constants.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int unsigned DIV_STEPS = 13;

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   localparam logic [1:0] CAT_NATURE   = 2'd0;
   localparam logic [1:0] CAT_NEUTRAL  = 2'd1;
   localparam logic [1:0] CAT_BUILDING = 2'd2;
   localparam logic [1:0] CAT_ACCENT   = 2'd3;

   localparam logic [4:0] NAME_BLACK       = 5'd0;
   localparam logic [4:0] NAME_WHITE       = 5'd1;
   localparam logic [4:0] NAME_DARK_GRAY   = 5'd2;
   localparam logic [4:0] NAME_GRAY        = 5'd3;
   localparam logic [4:0] NAME_LIGHT_GRAY  = 5'd4;
   localparam logic [4:0] NAME_DARK_RED    = 5'd5;
   localparam logic [4:0] NAME_PINK        = 5'd6;
   localparam logic [4:0] NAME_RED         = 5'd7;
   localparam logic [4:0] NAME_BROWN       = 5'd8;
   localparam logic [4:0] NAME_DARK_ORANGE = 5'd9;
   localparam logic [4:0] NAME_ORANGE      = 5'd10;
   localparam logic [4:0] NAME_TAN         = 5'd11;
   localparam logic [4:0] NAME_DARK_YELLOW = 5'd12;
   localparam logic [4:0] NAME_YELLOW      = 5'd13;
   localparam logic [4:0] NAME_DARK_GREEN  = 5'd14;
   localparam logic [4:0] NAME_LIGHT_GREEN = 5'd15;
   localparam logic [4:0] NAME_GREEN       = 5'd16;
   localparam logic [4:0] NAME_CYAN        = 5'd17;
   localparam logic [4:0] NAME_LIGHT_BLUE  = 5'd18;
   localparam logic [4:0] NAME_DARK_BLUE   = 5'd19;
   localparam logic [4:0] NAME_BLUE        = 5'd20;
   localparam logic [4:0] NAME_PURPLE      = 5'd21;
   localparam logic [4:0] NAME_VIOLET      = 5'd22;
   localparam logic [4:0] NAME_MAGENTA     = 5'd23;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [15:0] tag_out;
      logic [12:0] hue;
      logic [12:0] saturation;
      logic [8:0]  lightness_sum;
      logic [4:0]  color_name;
      logic [1:0]  category;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  sel;
      logic [7:0]  diff;
      logic [8:0]  sum;
   } pre_type;

   typedef struct packed {
      logic [7:0]  rem;
      logic [12:0] work;
      logic [7:0]  divisor;
   } div_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [8:0]  sum;
      logic        neutral;
      logic        sat_half;
      div_type     hdiv;
      div_type     sdiv;
   } mid_type;

endpackage
`default_nettype wire

FILE: sv/rgb_to_hsl_color_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL color classifier
// Converts an 8-bit RGB pixel to hue, saturation and lightness sum and
// classifies it into a color name and a category.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless req_stall is raised, and
// carries it to the response through sixteen register stages: two
// preparation stages, thirteen stages of a radix-2 restoring divider that
// produce hue and saturation side by side, and a classification stage that
// holds the response. Every stage has its own valid bit and loads whenever it
// is empty or its successor moves, so bubbles are squeezed out and a stalled
// response holds while earlier stages keep filling.
module rgb_to_hsl_color_classifier (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rhc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rhc_pkg::rsp_type      rsp_data
);

   localparam int unsigned NST = rhc_pkg::DIV_STEPS + 3;

   logic [NST-1:0]   vld;
   logic [NST-1:0]   adv;
   rhc_pkg::pre_type pre;
   rhc_pkg::mid_type mid [0:rhc_pkg::DIV_STEPS];

   assign adv[NST-1] = !vld[NST-1] || !rsp_stall;
   for (genvar k = 0; k < NST - 1; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
   end

   rhc_prep_a u_prep_a (
      .clock     (clock),
      .reset     (reset),
      .en        (adv[0]),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (vld[0]),
      .out_data  (pre)
   );

   rhc_prep_b u_prep_b (
      .clock     (clock),
      .reset     (reset),
      .en        (adv[1]),
      .in_valid  (vld[0]),
      .in_data   (pre),
      .out_valid (vld[1]),
      .out_data  (mid[0])
   );

   for (genvar k = 0; k < rhc_pkg::DIV_STEPS; k++) begin : g_div
      rhc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (adv[k+2]),
         .in_valid  (vld[k+1]),
         .in_data   (mid[k]),
         .out_valid (vld[k+2]),
         .out_data  (mid[k+1])
      );
   end

   rhc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .en        (adv[NST-1]),
      .in_valid  (vld[NST-2]),
      .in_data   (mid[rhc_pkg::DIV_STEPS]),
      .out_valid (vld[NST-1]),
      .out_data  (rsp_data)
   );

   assign req_stall = !adv[0];
   assign rsp_valid = vld[NST-1];

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.saturation <= 13'd4096)
      else $error("saturation out of range");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hue < 13'd5760)
      else $error("hue out of range");

   a_gray_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.color_name <= rhc_pkg::NAME_LIGHT_GRAY)
         |-> rsp_data.category == rhc_pkg::CAT_NEUTRAL)
      else $error("gray color name without neutral category");

endmodule
`default_nettype wire

FILE: sv/rhc_prep_a.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First preparation stage
// Finds the maximum and minimum channel, their difference and their sum.
// ----------------------------------------------------------------------------
module rhc_prep_a (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire rhc_pkg::req_type in_data,
   output logic                 out_valid,
   output rhc_pkg::pre_type     out_data
);

   logic             valid_ff;
   rhc_pkg::pre_type data_ff, data_in;
   logic [7:0]       mx, mn;

   always_comb begin
      if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
         mx = in_data.red;
         data_in.sel = rhc_pkg::SEL_RED;
      end else if (in_data.green >= in_data.blue) begin
         mx = in_data.green;
         data_in.sel = rhc_pkg::SEL_GREEN;
      end else begin
         mx = in_data.blue;
         data_in.sel = rhc_pkg::SEL_BLUE;
      end
      mn = in_data.red;
      if (in_data.green < mn) mn = in_data.green;
      if (in_data.blue < mn) mn = in_data.blue;
      data_in.tag   = in_data.tag;
      data_in.red   = in_data.red;
      data_in.green = in_data.green;
      data_in.blue  = in_data.blue;
      data_in.diff  = mx - mn;
      data_in.sum   = {1'b0, mx} + {1'b0, mn};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: sv/rhc_prep_b.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Second preparation stage
// Forms the hue numerator, the saturation divisor and the saturation flags,
// and loads the initial state of both dividers.
// ----------------------------------------------------------------------------
module rhc_prep_b (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire rhc_pkg::pre_type in_data,
   output logic                 out_valid,
   output rhc_pkg::mid_type     out_data
);

   logic             valid_ff;
   rhc_pkg::mid_type data_ff, data_in;
   logic             chroma;
   logic [8:0]       den9;
   logic [7:0]       den;
   logic [20:0]      hnum, snum, d21, r21, g21, b21;

   always_comb begin
      chroma = (in_data.diff != 8'd0);
      den9   = (in_data.sum > 9'd255) ? (9'd510 - in_data.sum) : in_data.sum;
      den    = den9[7:0];
      d21    = {13'd0, in_data.diff};
      r21    = {13'd0, in_data.red};
      g21    = {13'd0, in_data.green};
      b21    = {13'd0, in_data.blue};
      case (in_data.sel)
         rhc_pkg::SEL_RED: begin
            if (in_data.green >= in_data.blue) begin
               hnum = 21'd960 * (g21 - b21);
            end else begin
               hnum = 21'd5760 * d21 - 21'd960 * (b21 - g21);
            end
         end
         rhc_pkg::SEL_GREEN: begin
            hnum = 21'd1920 * d21 + 21'd960 * b21 - 21'd960 * r21;
         end
         default: begin
            hnum = 21'd3840 * d21 + 21'd960 * r21 - 21'd960 * g21;
         end
      endcase
      snum = {1'b0, in_data.diff, 12'd0};
      if (!chroma) begin
         hnum = 21'd0;
      end
      data_in.tag      = in_data.tag;
      data_in.sum      = in_data.sum;
      data_in.neutral  = !chroma ||
                         ((14'd20 * {6'd0, in_data.diff}) < (14'd3 * {6'd0, den}));
      data_in.sat_half = ({in_data.diff, 1'b0} < {1'b0, den});
      data_in.hdiv.rem     = hnum[20:13];
      data_in.hdiv.work    = hnum[12:0];
      data_in.hdiv.divisor = chroma ? in_data.diff : 8'd1;
      data_in.sdiv.rem     = snum[20:13];
      data_in.sdiv.work    = snum[12:0];
      data_in.sdiv.divisor = chroma ? den : 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: sv/rhc_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider stage
// One restoring division step for both the hue and the saturation quotient.
// ----------------------------------------------------------------------------
module rhc_div_step (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire rhc_pkg::mid_type in_data,
   output logic                 out_valid,
   output rhc_pkg::mid_type     out_data
);

   logic             valid_ff;
   rhc_pkg::mid_type data_ff, data_in;

   function automatic rhc_pkg::div_type div_step(input rhc_pkg::div_type cur);
      rhc_pkg::div_type nxt;
      logic [8:0]       trial;
      logic             ge;
      trial = {cur.rem, cur.work[12]};
      ge    = (trial >= {1'b0, cur.divisor});
      nxt.divisor = cur.divisor;
      nxt.rem     = ge ? 8'(trial - {1'b0, cur.divisor}) : trial[7:0];
      nxt.work    = {cur.work[11:0], ge};
      return nxt;
   endfunction

   always_comb begin
      data_in      = in_data;
      data_in.hdiv = div_step(in_data.hdiv);
      data_in.sdiv = div_step(in_data.sdiv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: sv/rhc_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classification stage
// Maps lightness, saturation flags and hue to a color name and a category,
// and holds the response register.
// ----------------------------------------------------------------------------
module rhc_classify (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire rhc_pkg::mid_type in_data,
   output logic                 out_valid,
   output rhc_pkg::rsp_type     out_data
);

   logic             valid_ff;
   rhc_pkg::rsp_type data_ff, data_in;
   logic [13:0]      s14;
   logic [12:0]      h;
   logic             l_lt_04, l_gt_07, l_lt_05, l_lt_035, l_gt_06, low;

   always_comb begin
      s14      = {5'd0, in_data.sum};
      h        = in_data.hdiv.work;
      l_lt_04  = (14'd5 * s14) < 14'd1020;
      l_gt_07  = (14'd10 * s14) > 14'd3570;
      l_lt_05  = in_data.sum < 9'd255;
      l_lt_035 = (14'd20 * s14) < 14'd3570;
      l_gt_06  = (14'd5 * s14) > 14'd1530;
      low      = in_data.sat_half && l_lt_05;
      data_in.tag_out       = in_data.tag;
      data_in.hue           = h;
      data_in.saturation    = in_data.sdiv.work;
      data_in.lightness_sum = in_data.sum;
      data_in.category      = rhc_pkg::CAT_ACCENT;
      if ((14'd20 * s14) < 14'd1530) begin
         data_in.color_name = rhc_pkg::NAME_BLACK;
         data_in.category   = rhc_pkg::CAT_NEUTRAL;
      end else if ((14'd20 * s14) > 14'd8670) begin
         data_in.color_name = rhc_pkg::NAME_WHITE;
         data_in.category   = rhc_pkg::CAT_NEUTRAL;
      end else if (in_data.neutral) begin
         data_in.category = rhc_pkg::CAT_NEUTRAL;
         if (l_lt_04) data_in.color_name = rhc_pkg::NAME_DARK_GRAY;
         else if (!l_gt_07 && in_data.sum != 9'd357) data_in.color_name = rhc_pkg::NAME_GRAY;
         else data_in.color_name = rhc_pkg::NAME_LIGHT_GRAY;
      end else if (h < 13'd240 || h >= 13'd5520) begin
         data_in.color_name = l_lt_04 ? rhc_pkg::NAME_DARK_RED :
                              (l_gt_07 ? rhc_pkg::NAME_PINK : rhc_pkg::NAME_RED);
      end else if (h < 13'd720) begin
         if (low) begin
            data_in.color_name = rhc_pkg::NAME_BROWN;
            data_in.category   = rhc_pkg::CAT_NATURE;
         end else begin
            data_in.color_name = l_lt_05 ? rhc_pkg::NAME_DARK_ORANGE : rhc_pkg::NAME_ORANGE;
         end
      end else if (h < 13'd1120) begin
         if (low) begin
            data_in.color_name = rhc_pkg::NAME_TAN;
            data_in.category   = rhc_pkg::CAT_NATURE;
         end else begin
            data_in.color_name = l_lt_05 ? rhc_pkg::NAME_DARK_YELLOW : rhc_pkg::NAME_YELLOW;
         end
      end else if (h < 13'd2560) begin
         data_in.category   = rhc_pkg::CAT_NATURE;
         data_in.color_name = l_lt_035 ? rhc_pkg::NAME_DARK_GREEN :
                              (l_gt_06 ? rhc_pkg::NAME_LIGHT_GREEN : rhc_pkg::NAME_GREEN);
      end else if (h < 13'd3200) begin
         data_in.color_name = rhc_pkg::NAME_CYAN;
      end else if (h < 13'd4160) begin
         if (l_gt_06) begin
            data_in.color_name = rhc_pkg::NAME_LIGHT_BLUE;
            data_in.category   = rhc_pkg::CAT_NATURE;
         end else begin
            data_in.color_name = l_lt_04 ? rhc_pkg::NAME_DARK_BLUE : rhc_pkg::NAME_BLUE;
            data_in.category   = rhc_pkg::CAT_BUILDING;
         end
      end else if (h < 13'd4800) begin
         data_in.color_name = l_lt_05 ? rhc_pkg::NAME_PURPLE : rhc_pkg::NAME_VIOLET;
      end else begin
         data_in.color_name = l_lt_05 ? rhc_pkg::NAME_MAGENTA : rhc_pkg::NAME_PINK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL classifier testbench
// Drives directed and random pixels in bursts, stalls responses on a
// pattern, and checks every response against an in-bench color predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 900;
   localparam int LATENCY        = 16;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   rhc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rhc_pkg::rsp_type rsp_data;

   rhc_pkg::rsp_type pending_colors[$];
   int               mismatch_count;
   int               response_count;
   bit               stall_enable;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] tag;
      bit          known;
      logic [4:0]  color_name;
      logic [1:0]  category;
   } pixel_row_type;

   pixel_row_type pixel_rows[DIRECTED_COUNT];

   rgb_to_hsl_color_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rhc_pkg::rsp_type classify_pixel(rhc_pkg::req_type px);
      rhc_pkg::rsp_type res;
      int unsigned r, g, b, mx, mn, d, sum, den, hnum;
      bit chroma, l_lt_04, l_gt_07, l_lt_05, l_lt_035, l_gt_06, s_lt_05;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      chroma = (d != 0);
      den = 1;
      hnum = 0;
      res = '0;
      res.tag_out = px.tag;
      res.lightness_sum = sum[8:0];
      if (chroma) begin
         den = (sum > 255) ? (510 - sum) : sum;
         res.saturation = 13'((4096 * d) / den);
         if (mx == r) begin
            if (g >= b) hnum = 960 * (g - b);
            else hnum = 5760 * d - 960 * (b - g);
         end else if (mx == g) begin
            hnum = 1920 * d + 960 * b - 960 * r;
         end else begin
            hnum = 3840 * d + 960 * r - 960 * g;
         end
         res.hue = 13'(hnum / d);
      end
      l_lt_04  = (5 * sum < 1020);
      l_gt_07  = (10 * sum > 3570);
      l_lt_05  = (sum < 255);
      l_lt_035 = (20 * sum < 3570);
      l_gt_06  = (5 * sum > 1530);
      s_lt_05  = (2 * d < den);
      if (20 * sum < 1530) begin
         res.color_name = rhc_pkg::NAME_BLACK;
         res.category = rhc_pkg::CAT_NEUTRAL;
      end else if (20 * sum > 8670) begin
         res.color_name = rhc_pkg::NAME_WHITE;
         res.category = rhc_pkg::CAT_NEUTRAL;
      end else if (!chroma || 20 * d < 3 * den) begin
         res.category = rhc_pkg::CAT_NEUTRAL;
         if (l_lt_04) res.color_name = rhc_pkg::NAME_DARK_GRAY;
         else if (10 * sum < 3570) res.color_name = rhc_pkg::NAME_GRAY;
         else res.color_name = rhc_pkg::NAME_LIGHT_GRAY;
      end else if (hnum < 240 * d || hnum >= 5520 * d) begin
         res.category = rhc_pkg::CAT_ACCENT;
         res.color_name = l_lt_04 ? rhc_pkg::NAME_DARK_RED
                        : (l_gt_07 ? rhc_pkg::NAME_PINK : rhc_pkg::NAME_RED);
      end else if (hnum < 720 * d) begin
         if (s_lt_05 && l_lt_05) begin
            res.color_name = rhc_pkg::NAME_BROWN;
            res.category = rhc_pkg::CAT_NATURE;
         end else begin
            res.color_name = l_lt_05 ? rhc_pkg::NAME_DARK_ORANGE : rhc_pkg::NAME_ORANGE;
            res.category = rhc_pkg::CAT_ACCENT;
         end
      end else if (hnum < 1120 * d) begin
         if (s_lt_05 && l_lt_05) begin
            res.color_name = rhc_pkg::NAME_TAN;
            res.category = rhc_pkg::CAT_NATURE;
         end else begin
            res.color_name = l_lt_05 ? rhc_pkg::NAME_DARK_YELLOW : rhc_pkg::NAME_YELLOW;
            res.category = rhc_pkg::CAT_ACCENT;
         end
      end else if (hnum < 2560 * d) begin
         res.category = rhc_pkg::CAT_NATURE;
         res.color_name = l_lt_035 ? rhc_pkg::NAME_DARK_GREEN
                        : (l_gt_06 ? rhc_pkg::NAME_LIGHT_GREEN : rhc_pkg::NAME_GREEN);
      end else if (hnum < 3200 * d) begin
         res.color_name = rhc_pkg::NAME_CYAN;
         res.category = rhc_pkg::CAT_ACCENT;
      end else if (hnum < 4160 * d) begin
         if (l_gt_06) begin
            res.color_name = rhc_pkg::NAME_LIGHT_BLUE;
            res.category = rhc_pkg::CAT_NATURE;
         end else begin
            res.color_name = l_lt_04 ? rhc_pkg::NAME_DARK_BLUE : rhc_pkg::NAME_BLUE;
            res.category = rhc_pkg::CAT_BUILDING;
         end
      end else if (hnum < 4800 * d) begin
         res.color_name = l_lt_05 ? rhc_pkg::NAME_PURPLE : rhc_pkg::NAME_VIOLET;
         res.category = rhc_pkg::CAT_ACCENT;
      end else begin
         res.color_name = l_lt_05 ? rhc_pkg::NAME_MAGENTA : rhc_pkg::NAME_PINK;
         res.category = rhc_pkg::CAT_ACCENT;
      end
      return res;
   endfunction

   function automatic pixel_row_type mk_row(int r, int g, int b, int t, bit k,
                                            logic [4:0] nm, logic [1:0] ct);
      pixel_row_type row;
      row.red = 8'(r);
      row.green = 8'(g);
      row.blue = 8'(b);
      row.tag = 16'(t);
      row.known = k;
      row.color_name = nm;
      row.category = ct;
      return row;
   endfunction

   initial begin
      pixel_rows[0]  = mk_row(0, 0, 0, 16'h0000, 1, rhc_pkg::NAME_BLACK,
                              rhc_pkg::CAT_NEUTRAL);
      pixel_rows[1]  = mk_row(255, 255, 255, 16'hFFFF, 1, rhc_pkg::NAME_WHITE,
                              rhc_pkg::CAT_NEUTRAL);
      pixel_rows[2]  = mk_row(128, 128, 128, 16'h5555, 1, rhc_pkg::NAME_GRAY,
                              rhc_pkg::CAT_NEUTRAL);
      pixel_rows[3]  = mk_row(80, 80, 80, 16'hAAAA, 1, rhc_pkg::NAME_DARK_GRAY,
                              rhc_pkg::CAT_NEUTRAL);
      pixel_rows[4]  = mk_row(200, 200, 200, 16'h1234, 1, rhc_pkg::NAME_LIGHT_GRAY,
                              rhc_pkg::CAT_NEUTRAL);
      pixel_rows[5]  = mk_row(255, 0, 0, 16'h0001, 0, '0, '0);
      pixel_rows[6]  = mk_row(0, 255, 0, 16'h0002, 0, '0, '0);
      pixel_rows[7]  = mk_row(0, 0, 255, 16'h0003, 0, '0, '0);
      pixel_rows[8]  = mk_row(255, 255, 0, 16'h0004, 0, '0, '0);
      pixel_rows[9]  = mk_row(0, 255, 255, 16'h0005, 0, '0, '0);
      pixel_rows[10] = mk_row(255, 0, 255, 16'h0006, 0, '0, '0);
      pixel_rows[11] = mk_row(255, 1, 255, 16'h0007, 0, '0, '0);
      pixel_rows[12] = mk_row(120, 60, 20, 16'h0008, 0, '0, '0);
      pixel_rows[13] = mk_row(255, 128, 0, 16'h0009, 0, '0, '0);
      pixel_rows[14] = mk_row(100, 90, 40, 16'h000A, 0, '0, '0);
      pixel_rows[15] = mk_row(200, 230, 200, 16'h000B, 0, '0, '0);
      pixel_rows[16] = mk_row(150, 200, 255, 16'h000C, 0, '0, '0);
      pixel_rows[17] = mk_row(120, 30, 200, 16'h000D, 0, '0, '0);
      pixel_rows[18] = mk_row(255, 180, 200, 16'h000E, 0, '0, '0);
      pixel_rows[19] = mk_row(40, 0, 0, 16'h000F, 0, '0, '0);
      pixel_rows[20] = mk_row(255, 0, 1, 16'h0010, 0, '0, '0);
      pixel_rows[21] = mk_row(1, 0, 0, 16'h8000, 0, '0, '0);
   end

   // The receiver stalls on a counter-driven pattern of quiet, busy and randomly stalled stretches.
   initial begin
      int phase;
      rsp_stall <= 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (!stall_enable || (phase % 400) < 60) rsp_stall <= 1'b0;
         else if ((phase % 97) < 20) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      rhc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (pending_colors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %p", rsp_data);
         end else begin
            want = pending_colors.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   task automatic send_pixel(rhc_pkg::req_type px, bit known, logic [4:0] nm,
                             logic [1:0] ct);
      rhc_pkg::rsp_type want;
      want = classify_pixel(px);
      if (known && (want.color_name !== nm || want.category !== ct)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("predictor disagrees on row %p: expected %0d/%0d, got %0d/%0d",
                     px, nm, ct, want.color_name, want.category);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_stall);
      pending_colors = {pending_colors, want};
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic rhc_pkg::req_type random_pixel();
      rhc_pkg::req_type px;
      px.tag = 16'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            px.red = 8'($urandom);
            px.green = px.red;
            px.blue = px.red;
         end
         1: begin
            px.red = 8'($urandom);
            px.green = ($urandom_range(0, 1)) ? px.red : 8'($urandom);
            px.blue = ($urandom_range(0, 1)) ? px.red : px.green;
         end
         2: begin
            px.red = 8'($urandom_range(0, 255));
            px.green = 8'(px.red + $urandom_range(0, 40) - 20);
            px.blue = 8'(px.red + $urandom_range(0, 40) - 20);
         end
         default: begin
            px.red = 8'($urandom);
            px.green = 8'($urandom);
            px.blue = 8'($urandom);
         end
      endcase
      return px;
   endfunction

   initial begin
      rhc_pkg::req_type px;
      int burst, wait_cycles;
      mismatch_count = 0;
      response_count = 0;
      stall_enable = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_enable = 1'b1;
      foreach (pixel_rows[i]) begin
         px.red = pixel_rows[i].red;
         px.green = pixel_rows[i].green;
         px.blue = pixel_rows[i].blue;
         px.tag = pixel_rows[i].tag;
         send_pixel(px, pixel_rows[i].known, pixel_rows[i].color_name,
                    pixel_rows[i].category);
      end
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      burst = 0;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (burst == 0) begin
            idle_gap();
            burst = $urandom_range(1, 40);
         end
         burst--;
         send_pixel(random_pixel(), 1'b0, '0, '0);
         if (n == RANDOM_COUNT / 2) begin
            req_valid <= 1'b0;
            while (pending_colors.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_colors.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      mismatch_count += pending_colors.size();
      $display("Sent %0d directed and %0d random pixels, %0d responses checked.",
               DIRECTED_COUNT, RANDOM_COUNT, response_count);
      $display("Coverage: grays, extremes, tied maxima, all hue sectors, bursts.");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
sv/rhc_pkg.sv
sv/rhc_prep_a.sv
sv/rhc_prep_b.sv
sv/rhc_div_step.sv
sv/rhc_classify.sv
sv/rgb_to_hsl_color_classifier.sv
verif/tb_top.sv
